[design/fspa_pkg.sv]
// shared types and constants for the fixed slot pool allocator
// used by fspa_stack_ram, fspa_used_ram and fixed_slot_pool_allocator
package fspa_pkg;

  // pool geometry, both powers of two
  localparam int POOL_SLOTS = 64;
  localparam int SLOT_BYTES = 256;
  localparam int IDX_W      = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int OFS_W      = $clog2(SLOT_BYTES);
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_INDEX_W = 6;
  localparam logic [ADDR_W:0] AREA_BYTES = (ADDR_W + 1)'(POOL_SLOTS * SLOT_BYTES);

  // request codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_USED   = 3'd6;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] release_address;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [ADDR_W-1:0]       slot_address;
  } out_word_t;

  // free index stack port
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
  } stk_req_t;

  // in-use bitmap port
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_data;
  } used_req_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

[design/fixed_slot_pool_allocator.sv]
// top level of the fixed slot pool allocator
// depends on fspa_pkg, fspa_stack_ram and fspa_used_ram
//
// Hands out and takes back 64 slots of 256 bytes starting at pool_base. Each
// request word gives exactly one result word, in order. In the accept cycle
// (S_IDLE) the release address is checked and the free stack top and the
// in-use bit are read from their memories; in S_EXEC the read data comes back
// and, once the output register can take it, the result is formed and the
// memories and free count are written back. No new request is taken until
// the block is back in S_IDLE. The result sits in an output register, so a
// stalled result holds up the block only when the next result is ready to
// leave. No clearing pass is needed after reset. The user is to write pool_base
// through the cfg port while no request is in flight; the block does not check.
module fixed_slot_pool_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fspa_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fspa_pkg::out_word_t           out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fspa_pkg::ADDR_W-1:0]   cfg_data
);
  import fspa_pkg::*;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] pool_base_r;
  logic [CNT_W-1:0]  free_count_r, free_count_nxt;
  logic              out_valid_r;
  out_word_t         out_word_r, result;
  logic              load_out;

  // request held from the accept cycle into S_EXEC
  logic              func_r;
  logic              chk_fail_r;
  logic [STATUS_W-1:0] chk_status_r;
  logic [IDX_W-1:0]  rel_idx_r;

  stk_req_t          stk_req;
  used_req_t         used_req;
  logic [IDX_W-1:0]  stk_rd_data;
  logic              used_rd_data;

  logic              in_accept;
  logic [ADDR_W:0]   diff;
  logic [ADDR_W-1:0] offset;
  logic              below, beyond, misaligned;
  logic [IDX_W-1:0]  rel_idx;
  logic              chk_fail;
  logic [STATUS_W-1:0] chk_status;
  logic [IDX_W-1:0]  top_addr;

  fspa_stack_ram u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (stk_req),
    .rd_data (stk_rd_data)
  );

  fspa_used_ram u_used (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (used_req),
    .rd_data (used_rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  // release address checks, done in the accept cycle
  assign diff       = {1'b0, in_word.release_address} - {1'b0, pool_base_r};
  assign below      = diff[ADDR_W];
  assign offset     = diff[ADDR_W-1:0];
  assign beyond     = {1'b0, offset} >= AREA_BYTES;
  assign misaligned = offset[OFS_W-1:0] != '0;
  assign rel_idx    = offset[OFS_W +: IDX_W];
  assign top_addr   = IDX_W'(free_count_r - CNT_W'(1));

  always_comb begin
    chk_fail   = 1'b1;
    chk_status = ST_NULL;
    if (in_word.release_address == '0) begin
      chk_status = ST_NULL;
    end else if (below || beyond) begin
      chk_status = ST_RANGE;
    end else if (misaligned) begin
      chk_status = ST_MISALIGNED;
    end else begin
      chk_fail   = 1'b0;
      chk_status = ST_NOT_USED;
    end
  end

  // sequencer: memory reads on accept, modify and write back in S_EXEC once the output register is free
  // in idle the input is never stalled, so valid alone marks an accept
  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    load_out       = 1'b0;
    free_count_nxt = free_count_r;
    result         = '0;
    stk_req        = '0;
    used_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_stall         = 1'b0;
        stk_req.rd_en    = in_valid;
        stk_req.rd_addr  = top_addr;
        used_req.rd_en   = in_valid;
        used_req.rd_addr = rel_idx;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          if (func_r == FUNC_ALLOC) begin
            if (free_count_r == '0) begin
              result.status = ST_EXHAUSTED;
            end else begin
              result.status       = ST_ALLOCATED;
              result.slot_index   = SLOT_INDEX_W'(stk_rd_data);
              result.slot_address = pool_base_r
                                  + (ADDR_W'(stk_rd_data) << OFS_W);
              free_count_nxt      = free_count_r - CNT_W'(1);
              used_req.wr_en      = 1'b1;
              used_req.wr_addr    = stk_rd_data;
              used_req.wr_data    = 1'b1;
            end
          end else begin
            if (chk_fail_r) begin
              result.status = chk_status_r;
            end else if (!used_rd_data) begin
              result.status = ST_NOT_USED;
            end else begin
              result.status     = ST_RELEASED;
              result.slot_index = SLOT_INDEX_W'(rel_idx_r);
              used_req.wr_en    = 1'b1;
              used_req.wr_addr  = rel_idx_r;
              used_req.wr_data  = 1'b0;
              // push dropped when the stack is already full
              if (free_count_r < CNT_W'(POOL_SLOTS)) begin
                stk_req.wr_en   = 1'b1;
                stk_req.wr_addr = IDX_W'(free_count_r);
                stk_req.wr_data = rel_idx_r;
                free_count_nxt  = free_count_r + CNT_W'(1);
              end
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_count_r <= CNT_W'(POOL_SLOTS);
      out_valid_r  <= 1'b0;
      pool_base_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        pool_base_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r       <= in_word.func;
      chk_fail_r   <= chk_fail;
      chk_status_r <= chk_status;
      rel_idx_r    <= rel_idx;
    end
    if (load_out) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[design/fspa_stack_ram.sv]
// free index stack: synchronous memory with registered read data
// an entry never written reads as its own index; depends on fspa_pkg
module fspa_stack_ram (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fspa_pkg::stk_req_t             req,
  output logic [fspa_pkg::IDX_W-1:0]     rd_data
);
  import fspa_pkg::*;

  logic [IDX_W-1:0]      stack_mem_r [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] vld_r;
  logic [IDX_W-1:0]      rd_word_r;
  logic [IDX_W-1:0]      rd_addr_r;
  logic                  rd_vld_r;

  // memory array write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      stack_mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= stack_mem_r[req.rd_addr];
      rd_addr_r <= req.rd_addr;
      rd_vld_r  <= vld_r[req.rd_addr];
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // unwritten entry reads as its reset value, the index itself
  assign rd_data = rd_vld_r ? rd_word_r : rd_addr_r;

endmodule

[design/fspa_used_ram.sv]
// per-slot in-use bitmap: synchronous memory with registered read data
// an entry never written reads as free; depends on fspa_pkg
module fspa_used_ram (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fspa_pkg::used_req_t   req,
  output logic                  rd_data
);
  import fspa_pkg::*;

  logic                  used_mem_r [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] vld_r;
  logic                  rd_bit_r;
  logic                  rd_vld_r;

  // memory array write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      used_mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_bit_r <= used_mem_r[req.rd_addr];
      rd_vld_r <= vld_r[req.rd_addr];
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r & rd_bit_r;

endmodule

[dv/fixed_slot_pool_allocator_tb.sv]
// self-checking testbench for fixed_slot_pool_allocator: allocate and release words
// are checked against an in-bench model of the free stack and in-use bitmap
// depends on fspa_pkg and the fixed_slot_pool_allocator rtl
module fixed_slot_pool_allocator_tb;
  import fspa_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [ADDR_W:0] POOL_SPAN = (ADDR_W + 1)'(POOL_SLOTS * SLOT_BYTES);

  // whole allocator state: base register, stack depth, in-use bits, free stack
  typedef struct packed {
    logic [ADDR_W-1:0]                  base;
    logic [CNT_W-1:0]                   count;
    logic [POOL_SLOTS-1:0]              used;
    logic [POOL_SLOTS-1:0][IDX_W-1:0]   stack;
  } pool_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  in_word_t      in_word = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  out_word_t     out_word;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [ADDR_W-1:0] cfg_data = '0;

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  pool_t     plan_pool;
  pool_t     live_pool;
  logic      in_fire = 1'b0;
  bit        idle_on = 1'b1;
  int        hold_requests = 0;
  int        holds_served = 0;
  int        hold_left = 0;
  int        stall_left = 0;
  int        gap_left = 0;
  int        error_count = 0;
  int        results_checked = 0;
  int        base_writes = 0;
  int        cycle_count = 0;
  int        seen_status[8];

  fixed_slot_pool_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // state right after reset
  function automatic pool_t fresh_pool();
    pool_t p;
    p.base  = '0;
    p.count = CNT_W'(POOL_SLOTS);
    p.used  = '0;
    for (int i = 0; i < POOL_SLOTS; i++) p.stack[i] = IDX_W'(i);
    return p;
  endfunction

  // one request against a pool state, giving its result word
  task automatic serve_request(inout pool_t p, input in_word_t w, output out_word_t r);
    logic [ADDR_W:0]  ofs;
    logic [IDX_W-1:0] idx;
    r   = '0;
    ofs = {1'b0, w.release_address} - {1'b0, p.base};
    if (w.func == FUNC_ALLOC) begin
      if (p.count == 0) begin
        r.status = ST_EXHAUSTED;
      end else begin
        p.count        = p.count - 1'b1;
        idx            = p.stack[p.count[IDX_W-1:0]];
        p.used[idx]    = 1'b1;
        r.status       = ST_ALLOCATED;
        r.slot_index   = idx;
        r.slot_address = p.base + ADDR_W'(idx) * ADDR_W'(SLOT_BYTES);
      end
    end else if (w.release_address == '0) begin
      r.status = ST_NULL;
    end else if (w.release_address < p.base || ofs >= POOL_SPAN) begin
      r.status = ST_RANGE;
    end else if ((ofs % SLOT_BYTES) != 0) begin
      r.status = ST_MISALIGNED;
    end else begin
      idx = IDX_W'(ofs / SLOT_BYTES);
      if (!p.used[idx]) begin
        r.status = ST_NOT_USED;
      end else begin
        p.used[idx] = 1'b0;
        // push is dropped on a full stack
        if (p.count < POOL_SLOTS) begin
          p.stack[p.count[IDX_W-1:0]] = idx;
          p.count = p.count + 1'b1;
        end
        r.status     = ST_RELEASED;
        r.slot_index = idx;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 20)
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
               cycle_count, what, got, want);
    error_count++;
  endtask

  // random idle length: mostly none, some short, a few long
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // release address: mostly live slots, plus every kind of bad address
  function automatic logic [ADDR_W-1:0] release_target();
    int                r;
    int                k;
    int                idx;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] a;
    b   = plan_pool.base;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, POOL_SLOTS - 1);
    if (r < 50) begin
      for (k = 0; k < POOL_SLOTS && !plan_pool.used[idx]; k++) idx = (idx + 1) % POOL_SLOTS;
      a = b + idx * SLOT_BYTES;
    end else if (r < 62) begin
      a = b + idx * SLOT_BYTES;
    end else if (r < 70) begin
      a = b + idx * SLOT_BYTES + $urandom_range(1, SLOT_BYTES - 1);
    end else if (r < 74) begin
      a = b - 1;
    end else if (r < 78) begin
      a = b + POOL_SLOTS * SLOT_BYTES + $urandom_range(0, 3) * SLOT_BYTES;
    end else if (r < 83) begin
      a = b + POOL_SLOTS * SLOT_BYTES - 1;
    end else if (r < 88) begin
      a = '0;
    end else begin
      a = $urandom;
    end
    return a;
  endfunction

  // queue one request word, tracking the pool as the block will see it
  task automatic add_item(input logic f, input logic [ADDR_W-1:0] a);
    in_word_t  w;
    out_word_t r;
    w.func            = f;
    w.release_address = a;
    serve_request(plan_pool, w, r);
    pending_words.push_back(w);
  endtask

  task automatic queue_phase(input int n, input int alloc_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < alloc_pct) add_item(FUNC_ALLOC, $urandom);
      else add_item(FUNC_RELEASE, release_target());
    end
  endtask

  // let every queued word go through and every result come back
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pool_base(input logic [ADDR_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    plan_pool.base = v;
    base_writes++;
  endtask

  // request driver, fed from pending_words
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_words.size() > 0) begin
        in_word  <= pending_words.pop_front();
        in_valid <= 1'b1;
        gap_left = next_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, with an occasional long hold
  always @(negedge clk) begin
    if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = next_gap();
    end
  end

  // monitor: check result words, track config writes, predict accepted requests
  always @(posedge clk) begin : monitor
    out_word_t want;
    out_word_t got;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = out_word;
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected, status",
                          32'(got.status), '0);
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.slot_index != want.slot_index)
            report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
          if (got.slot_address != want.slot_address)
            report_mismatch("slot_address", got.slot_address, want.slot_address);
          seen_status[got.status]++;
          results_checked++;
        end
      end
      if (cfg_valid && cfg_ready) live_pool.base = cfg_data;
      if (in_valid && !in_stall) begin
        serve_request(live_pool, in_word, want);
        expected_results.push_back(want);
      end
      in_fire <= in_valid && !in_stall;
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fixed_slot_pool_allocator_tb: errors");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    int settle;
    plan_pool = fresh_pool();
    live_pool = fresh_pool();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // base 0: address 0 is null even though it is slot 0
    add_item(FUNC_ALLOC, '0);
    add_item(FUNC_ALLOC, '1);
    add_item(FUNC_RELEASE, 32'h0000_0000);
    add_item(FUNC_RELEASE, 32'h0000_3F00);
    add_item(FUNC_RELEASE, 32'h0000_3F00);
    add_item(FUNC_RELEASE, 32'h0000_3E80);
    add_item(FUNC_RELEASE, 32'h0000_4000);
    add_item(FUNC_RELEASE, 32'hFFFF_FFFF);
    add_item(FUNC_RELEASE, 32'h0000_3FFF);
    add_item(FUNC_RELEASE, 32'h0000_0100);
    add_item(FUNC_ALLOC, 32'h5555_AAAA);
    add_item(FUNC_RELEASE, 32'h0000_3E00);
    queue_phase(240, 55);
    drain();

    // allocate heavy, runs the pool dry
    write_pool_base(32'h0000_1000);
    queue_phase(260, 85);
    drain();

    // pool ends exactly at the top of the address space; long result hold
    write_pool_base(32'hFFFF_C000);
    add_item(FUNC_RELEASE, 32'hFFFF_FF00);
    hold_requests++;
    queue_phase(260, 50);
    drain();

    // highest base, no idling on either side
    idle_on = 1'b0;
    write_pool_base(32'hFFFF_FFFF);
    queue_phase(160, 60);
    drain();

    // slot addresses wrap past zero
    idle_on = 1'b1;
    write_pool_base(32'hFFFF_FF00);
    add_item(FUNC_ALLOC, $urandom);
    add_item(FUNC_RELEASE, 32'h0000_0000);
    add_item(FUNC_RELEASE, 32'hFFFF_FF00);
    add_item(FUNC_RELEASE, 32'hFFFF_FF01);
    queue_phase(200, 50);
    drain();

    // release heavy at base 0
    write_pool_base(32'h0000_0000);
    queue_phase(240, 25);
    drain();

    write_pool_base($urandom);
    hold_requests++;
    queue_phase(240, 50);

    // final drain with a bound
    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    settle = 0;
    while (expected_results.size() > 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);
    if (expected_results.size() > 0)
      report_mismatch("result words never seen, count", expected_results.size(), '0);

    $display("checked %0d result words over %0d pool_base settings, two long result holds",
             results_checked, base_writes + 1);
    $display("allocated %0d, exhausted %0d, released %0d, null %0d",
             seen_status[ST_ALLOCATED], seen_status[ST_EXHAUSTED],
             seen_status[ST_RELEASED], seen_status[ST_NULL]);
    $display("range %0d, misaligned %0d, not in use %0d",
             seen_status[ST_RANGE], seen_status[ST_MISALIGNED],
             seen_status[ST_NOT_USED]);
    if (error_count == 0) begin
      $display("fixed_slot_pool_allocator_tb: clean");
    end else begin
      $display("fixed_slot_pool_allocator_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
design/fspa_pkg.sv
design/fspa_stack_ram.sv
design/fspa_used_ram.sv
design/fixed_slot_pool_allocator.sv
dv/fixed_slot_pool_allocator_tb.sv
